/* sv/mcr_pkg.sv */
// Package for the MUSCL face reconstruction block: payload structs, config codes,
// and the limiter and saturation functions.
// No dependencies.
package mcr_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int FRAC       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_FLOOR  = 1'b1;

  typedef logic signed [31:0] q_t;
  typedef logic signed [51:0] wide_t;

  localparam q_t    Q_MAX = 32'sh7fffffff;
  localparam q_t    Q_MIN = 32'sh80000000;
  localparam wide_t W_MAX = 52'sd2147483647;
  localparam wide_t W_MIN = -52'sd2147483648;

  typedef struct packed {
    q_t far_saturation;
    q_t far_concentration;
    q_t far_permeability;
    q_t near_saturation;
    q_t near_concentration;
    q_t near_permeability;
    q_t next_saturation;
    q_t next_concentration;
    q_t next_permeability;
  } in_t;

  typedef struct packed {
    q_t face_saturation;
    q_t face_concentration;
    q_t face_permeability;
  } out_t;

  // front end result handed to the divider
  typedef struct packed {
    logic                  order;
    logic [CFG_DATA_W-1:0] floor_val;
    q_t                    face_s;
    q_t                    face_p;
    q_t                    near_c;
    wide_t                 bface;
  } front_t;

  function automatic q_t sat32(input wide_t x);
    q_t r;
    begin
      if (x > W_MAX) r = Q_MAX;
      else if (x < W_MIN) r = Q_MIN;
      else r = x[31:0];
      return r;
    end
  endfunction

  // minmod limited face value from backward, forward and central differences
  function automatic wide_t lim(input wide_t db, input wide_t df, input wide_t dc,
                                input wide_t u0);
    wide_t a;
    wide_t c;
    wide_t f;
    wide_t m;
    begin
      a = (db < 0 ? -db : db) <<< 2;
      f = (df < 0 ? -df : df) <<< 2;
      c = dc < 0 ? -dc : dc;
      m = '0;
      if ((db > 0 && df > 0) || (db < 0 && df < 0)) begin
        m = a;
        if (c < m) m = c;
        if (f < m) m = f;
        if (db < 0) m = -m;
      end
      return u0 + (m >>> 2);
    end
  endfunction

endpackage

/* sv/muscl_face_reconstruction.sv */
// Top level of the MUSCL face reconstruction block: config registers, front
// pipeline and divider pipeline. Uses mcr_pkg, mcr_front, mcr_div.
//
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | three cells (far, near, next)
//  out     | output    | out_valid / out_stall| face saturation, conc., perm.
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One beat per cycle in while in_stall is low; 3 front stages, 33 divider stages and
// an output register; the divider's one quotient bit per stage sets the depth.
// rst is synchronous and clears all valid bits and loads the register resets.
// A stalled valid output freezes the whole pipeline and raises in_stall.
// First-order mode rides the same pipeline.
module muscl_face_reconstruction (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mcr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mcr_pkg::out_t                   out_data,
  input  logic                            cfg_write,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                           order_mode;
  logic [mcr_pkg::CFG_DATA_W-1:0] saturation_floor;
  logic                           en;
  logic                           f_vld;
  mcr_pkg::front_t                f_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode       <= 1'b1;
      saturation_floor <= 17'd66;
    end else if (cfg_write) begin
      case (cfg_index)
        mcr_pkg::REG_ORDER_MODE: order_mode       <= cfg_data[0];
        mcr_pkg::REG_SAT_FLOOR:  saturation_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  mcr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_vld           (in_valid),
    .in_data          (in_data),
    .order_mode       (order_mode),
    .saturation_floor (saturation_floor),
    .out_vld          (f_vld),
    .out_data         (f_data)
  );

  mcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_data  (f_data),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule

/* sv/mcr_front.sv */
// Front pipeline: products, differences and limiters (three register stages).
// Uses mcr_pkg.
module mcr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  mcr_pkg::in_t    in_data,
  input  logic            order_mode,
  input  logic [mcr_pkg::CFG_DATA_W-1:0] saturation_floor,
  output logic            out_vld,
  output mcr_pkg::front_t out_data
);

  // stage A
  logic                  a_vld;
  logic                  a_order;
  logic [mcr_pkg::CFG_DATA_W-1:0] a_floor;
  logic signed [63:0]    a_pf, a_pn, a_px;
  mcr_pkg::wide_t        a_sdb, a_sdf, a_sdc, a_pdb, a_pdf, a_pdc;
  mcr_pkg::q_t           a_ns, a_np, a_nc;

  // stage B
  logic                  b_vld;
  logic                  b_order;
  logic [mcr_pkg::CFG_DATA_W-1:0] b_floor;
  mcr_pkg::q_t           b_fs, b_fp, b_nc;
  mcr_pkg::wide_t        b_bn, b_db, b_df, b_dc;

  mcr_pkg::wide_t        bf, bn, bx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
    if (en) begin
      a_order <= order_mode;
      a_floor <= saturation_floor;
      a_pf    <= in_data.far_saturation * in_data.far_concentration;
      a_pn    <= in_data.near_saturation * in_data.near_concentration;
      a_px    <= in_data.next_saturation * in_data.next_concentration;
      a_sdb   <= mcr_pkg::wide_t'(in_data.near_saturation)
                 - mcr_pkg::wide_t'(in_data.far_saturation);
      a_sdf   <= mcr_pkg::wide_t'(in_data.next_saturation)
                 - mcr_pkg::wide_t'(in_data.near_saturation);
      a_sdc   <= mcr_pkg::wide_t'(in_data.next_saturation)
                 - mcr_pkg::wide_t'(in_data.far_saturation);
      a_pdb   <= mcr_pkg::wide_t'(in_data.near_permeability)
                 - mcr_pkg::wide_t'(in_data.far_permeability);
      a_pdf   <= mcr_pkg::wide_t'(in_data.next_permeability)
                 - mcr_pkg::wide_t'(in_data.near_permeability);
      a_pdc   <= mcr_pkg::wide_t'(in_data.next_permeability)
                 - mcr_pkg::wide_t'(in_data.far_permeability);
      a_ns    <= in_data.near_saturation;
      a_np    <= in_data.near_permeability;
      a_nc    <= in_data.near_concentration;
    end
  end

  // floor of product / 2^16
  assign bf = mcr_pkg::wide_t'(a_pf >>> mcr_pkg::FRAC);
  assign bn = mcr_pkg::wide_t'(a_pn >>> mcr_pkg::FRAC);
  assign bx = mcr_pkg::wide_t'(a_px >>> mcr_pkg::FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_order <= a_order;
      b_floor <= a_floor;
      // first order passes the near cell through
      b_fs    <= a_order ? mcr_pkg::sat32(mcr_pkg::lim(a_sdb, a_sdf, a_sdc,
                                                       mcr_pkg::wide_t'(a_ns)))
                         : a_ns;
      b_fp    <= a_order ? mcr_pkg::sat32(mcr_pkg::lim(a_pdb, a_pdf, a_pdc,
                                                       mcr_pkg::wide_t'(a_np)))
                         : a_np;
      b_nc    <= a_nc;
      b_bn    <= bn;
      b_db    <= bn - bf;
      b_df    <= bx - bn;
      b_dc    <= bx - bf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= b_vld;
    end
    if (en) begin
      out_data.order     <= b_order;
      out_data.floor_val <= b_floor;
      out_data.face_s    <= b_fs;
      out_data.face_p    <= b_fp;
      out_data.near_c    <= b_nc;
      out_data.bface     <= mcr_pkg::lim(b_db, b_df, b_dc, b_bn);
    end
  end

endmodule

/* sv/mcr_div.sv */
// Pipelined restoring divider for the face concentration, one quotient bit per
// stage, plus final selection and output register. Uses mcr_pkg.
module mcr_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  mcr_pkg::front_t in_data,
  output logic            out_vld,
  output mcr_pkg::out_t   out_data
);

  typedef struct packed {
    logic        order;
    logic        gt;
    logic        neg;
    logic        ovf;
    logic [31:0] r;
    logic [31:0] low;
    logic [31:0] d;
    logic [31:0] q;
    mcr_pkg::q_t s;
    mcr_pkg::q_t p;
    mcr_pkg::q_t nc;
  } dv_t;

  dv_t  st  [0:32];
  logic vld [0:32];

  mcr_pkg::wide_t absb;
  logic [63:0]    mag;
  logic           big;
  mcr_pkg::q_t    cval;
  dv_t            lst;

  assign absb = in_data.bface < 0 ? -in_data.bface : in_data.bface;
  assign mag  = {absb[47:0], 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      st[0].order <= in_data.order;
      st[0].gt    <= in_data.face_s > $signed({15'b0, in_data.floor_val});
      st[0].neg   <= in_data.bface < 0;
      st[0].ovf   <= mag[63:32] >= in_data.face_s;
      st[0].r     <= mag[63:32];
      st[0].low   <= mag[31:0];
      st[0].d     <= in_data.face_s;
      st[0].q     <= '0;
      st[0].s     <= in_data.face_s;
      st[0].p     <= in_data.face_p;
      st[0].nc    <= in_data.near_c;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div
    dv_t         nx;
    logic [31:0] rr;
    always_comb begin
      nx     = st[k];
      rr     = {st[k].r[30:0], st[k].low[31]};
      nx.low = {st[k].low[30:0], 1'b0};
      if (rr >= st[k].d) begin
        nx.r = rr - st[k].d;
        nx.q = {st[k].q[30:0], 1'b1};
      end else begin
        nx.r = rr;
        nx.q = {st[k].q[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        st[k+1] <= nx;
      end
    end
  end

  assign lst = st[32];
  assign big = lst.ovf || (lst.q[31] && (lst.q[30:0] != '0));

  always_comb begin
    if (!lst.order) begin
      cval = lst.nc;
    end else if (!lst.gt) begin
      cval = '0;
    end else if (big) begin
      cval = lst.neg ? mcr_pkg::Q_MIN : mcr_pkg::Q_MAX;
    end else if (lst.neg) begin
      cval = -$signed(lst.q);
    end else if (lst.q[31]) begin
      cval = mcr_pkg::Q_MAX;
    end else begin
      cval = $signed(lst.q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[32];
    end
    if (en) begin
      out_data.face_saturation    <= lst.order ? lst.s : lst.s;
      out_data.face_concentration <= cval;
      out_data.face_permeability  <= lst.p;
    end
  end

endmodule

/* sv/mcr_checker.sv */
// Port-level checker for muscl_face_reconstruction, bound to the top level.
// Uses mcr_pkg.
module mcr_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input mcr_pkg::out_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data)) else $error("out beat changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall) else $error("in taken while out stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("out valid after reset");

endmodule

bind muscl_face_reconstruction mcr_checker u_mcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
